[hdl/ilp_pkg.sv]
// Shared types and constants for the integer literal parser.
// Holds the phase encoding, error and class codes, and the per-tag prefix table.
// No dependencies.
package ilp_pkg;

	// Parser phase
	typedef enum logic [1:0] {
		PH_PREFIX = 2'd0,
		PH_DIGITS = 2'd1,
		PH_SUFFIX = 2'd2,
		PH_DRAIN  = 2'd3
	} phase_t;

	// Error codes, first one wins
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_TOO_BIG = 2'd1;
	localparam logic [1:0] ERR_INVALID = 2'd2;

	// Type classes
	localparam logic [1:0] CLS_INT  = 2'd0;
	localparam logic [1:0] CLS_LONG = 2'd1;
	localparam logic [1:0] CLS_WIDE = 2'd2;

	// Radix tags
	localparam logic [1:0] RDX_DEC = 2'd0;
	localparam logic [1:0] RDX_HEX = 2'd1;
	localparam logic [1:0] RDX_OCT = 2'd2;
	localparam logic [1:0] RDX_BIN = 2'd3;

	// Character codes
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_1    = 8'h31;
	localparam logic [7:0] CH_7    = 8'h37;
	localparam logic [7:0] CH_8    = 8'h38;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;
	localparam logic [7:0] CH_UL   = 8'h4C;
	localparam logic [7:0] CH_UU   = 8'h55;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF   = 8'h66;
	localparam logic [7:0] CH_LL   = 8'h6C;
	localparam logic [7:0] CH_LU   = 8'h75;

	// Saturation point of the digit counter
	localparam logic [6:0] DC_MAX = 7'd127;

	// Control state besides the accumulator
	typedef struct packed {
		logic [6:0] digit_count;
		phase_t     phase;
		logic [1:0] prefix_left;
		logic       unsigned_seen;
		logic       long_seen;
		logic [1:0] first_error;
	} ctl_t;

	localparam ctl_t CTL_RESET = '{
		digit_count:   7'd0,
		phase:         PH_PREFIX,
		prefix_left:   2'd0,
		unsigned_seen: 1'b0,
		long_seen:     1'b0,
		first_error:   ERR_NONE
	};

	// Prefix length per radix tag ("", "0x", "0", "0b")
	function automatic logic [1:0] prefix_len(input logic [1:0] rdx);
		logic [1:0] len;
		unique case (rdx)
			RDX_DEC: len = 2'd0;
			RDX_HEX: len = 2'd2;
			RDX_OCT: len = 2'd1;
			default: len = 2'd2;
		endcase
		return len;
	endfunction

endpackage

[hdl/integer_literal_parser_core.sv]
// Integer literal parser: one character per transaction, result on the zero byte.
// The result passes through the input register and then the result register.
// Throughput: one character per cycle, but a terminator waits while an untaken result is held;
// the state loop runs through the digit update (shift-add by ten plus compare).
// Reset: arst_n clears all parser state and both valid flags; no clearing pass.
// Depends on ilp_pkg, ilp_step, ilp_emit.
module integer_literal_parser_core #(
	parameter int VALUE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic [1:0]  s_tuser,   // [1:0] radix
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [63:0] value, [65:64] type_class, [66] signed_flag,
	                               // [68:67] error, [71:69] zero
);
	import ilp_pkg::*;

	// Input register
	logic       vld_s1;
	logic [7:0] char_s1;
	logic [1:0] radix_s1;

	// Parser state
	logic [VALUE_BITS-1:0] acc_q;
	ctl_t                  ctl_q;

	// Result register
	logic        out_vld_q;
	logic [71:0] out_data_q;

	logic [VALUE_BITS-1:0] acc_nxt;
	ctl_t                  ctl_nxt;
	logic [63:0]           e_value;
	logic [1:0]            e_class;
	logic                  e_signed;
	logic [1:0]            e_error;
	logic                  is_term;
	logic                  consume;

	ilp_step #(.VALUE_BITS(VALUE_BITS)) u_step (
		.acc       (acc_q),
		.ctl       (ctl_q),
		.char_code (char_s1),
		.radix     (radix_s1),
		.acc_nxt   (acc_nxt),
		.ctl_nxt   (ctl_nxt)
	);

	ilp_emit #(.VALUE_BITS(VALUE_BITS)) u_emit (
		.acc         (acc_q),
		.ctl         (ctl_q),
		.value       (e_value),
		.type_class  (e_class),
		.signed_flag (e_signed),
		.error       (e_error)
	);

	// A terminator needs room in the result register; other characters always go
	assign is_term  = (char_s1 == CH_NUL);
	assign consume  = vld_s1 && (!is_term || !out_vld_q || m_tready);
	assign s_tready = !vld_s1 || consume;

	// Control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			acc_q     <= '0;
			ctl_q     <= CTL_RESET;
			out_vld_q <= 1'b0;
		end else begin
			if (s_tready)
				vld_s1 <= s_tvalid;
			// Result held until taken, reloaded by a terminator
			out_vld_q <= (consume && is_term) || (out_vld_q && !m_tready);
			if (consume) begin
				if (is_term) begin
					acc_q <= '0;
					ctl_q <= CTL_RESET;
				end else begin
					acc_q <= acc_nxt;
					ctl_q <= ctl_nxt;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1  <= s_tdata;
			radix_s1 <= s_tuser;
		end
		if (consume && is_term)
			out_data_q <= {3'b000, e_error, e_signed, e_class, e_value};
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

[hdl/ilp_step.sv]
// Next-state logic of the parser for one non-terminating character.
// Covers prefix skip, per-radix digit accumulation with overflow tests, suffixes.
// Depends on ilp_pkg.
module ilp_step #(
	parameter int VALUE_BITS = 64
) (
	input  logic [VALUE_BITS-1:0] acc,
	input  ilp_pkg::ctl_t         ctl,
	input  logic [7:0]            char_code,
	input  logic [1:0]            radix,
	output logic [VALUE_BITS-1:0] acc_nxt,
	output ilp_pkg::ctl_t         ctl_nxt
);
	import ilp_pkg::*;

	localparam logic [VALUE_BITS-1:0] MAXV    = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] DEC_LIM = MAXV / 10;
	localparam logic [6:0]            HEX_LIM = 7'(VALUE_BITS / 4);
	localparam logic [6:0]            BIN_LIM = 7'(VALUE_BITS);

	// Character classification
	logic       is_dec, is_oct, is_oct_bad, is_bin, is_hex_ul, is_hex_lc, is_hex_uc;
	logic [3:0] dec_d, hex_d;
	logic       is_u, is_l;
	logic [VALUE_BITS-1:0] prod;
	logic [6:0] dc_inc;

	assign is_dec     = (char_code >= CH_0) && (char_code <= CH_9);
	assign is_oct     = (char_code >= CH_0) && (char_code <= CH_7);
	assign is_oct_bad = (char_code == CH_8) || (char_code == CH_9);
	assign is_bin     = (char_code == CH_0) || (char_code == CH_1);
	assign is_hex_lc  = (char_code >= CH_LA) && (char_code <= CH_LF);
	assign is_hex_uc  = (char_code >= CH_UA) && (char_code <= CH_UF);
	assign is_hex_ul  = is_dec || is_hex_lc || is_hex_uc;
	assign dec_d      = 4'(char_code - CH_0);
	assign is_u       = (char_code == CH_LU) || (char_code == CH_UU);
	assign is_l       = (char_code == CH_LL) || (char_code == CH_UL);

	always_comb begin
		unique if (is_hex_lc)
			hex_d = 4'(char_code - CH_LA + 8'd10);
		else if (is_hex_uc)
			hex_d = 4'(char_code - CH_UA + 8'd10);
		else
			hex_d = dec_d;
	end

	// acc * 10, wrapping
	assign prod   = (acc << 3) + (acc << 1);
	assign dc_inc = (ctl.digit_count < DC_MAX) ? ctl.digit_count + 7'd1 : ctl.digit_count;

	// Phase sequencing, then digit, then suffix handling
	always_comb begin
		logic run_digit;
		logic run_suffix;
		logic [1:0] err;
		logic raise;
		logic [1:0] plen;
		logic [1:0] pl_dec;

		acc_nxt    = acc;
		ctl_nxt    = ctl;
		run_digit  = 1'b0;
		run_suffix = 1'b0;
		raise      = 1'b0;
		err        = ERR_NONE;
		plen       = prefix_len(radix);
		pl_dec     = ctl.prefix_left - 2'd1;

		unique case (ctl.phase)
			PH_PREFIX: begin
				if (ctl.prefix_left != 2'd0) begin
					ctl_nxt.prefix_left = pl_dec;
					if (pl_dec == 2'd0)
						ctl_nxt.phase = PH_DIGITS;
				end else if (plen != 2'd0) begin
					ctl_nxt.prefix_left = plen - 2'd1;
					if (plen == 2'd1)
						ctl_nxt.phase = PH_DIGITS;
				end else begin
					ctl_nxt.phase = PH_DIGITS;
					run_digit     = 1'b1;
				end
			end
			PH_DIGITS: run_digit  = 1'b1;
			PH_SUFFIX: run_suffix = 1'b1;
			default: ;
		endcase

		// Digit of the character's own radix
		if (run_digit) begin
			unique case (radix)
				RDX_DEC: begin
					if (is_dec) begin
						if ($signed(acc) > $signed(DEC_LIM)) begin
							raise = 1'b1;
							err   = ERR_TOO_BIG;
						end else begin
							acc_nxt = prod;
							if ($signed(prod) > $signed(MAXV - VALUE_BITS'(dec_d))) begin
								raise = 1'b1;
								err   = ERR_TOO_BIG;
							end else begin
								acc_nxt = prod + VALUE_BITS'(dec_d);
							end
						end
					end else begin
						run_suffix = 1'b1;
					end
				end
				RDX_HEX: begin
					if (is_hex_ul) begin
						ctl_nxt.digit_count = dc_inc;
						if (dc_inc > HEX_LIM) begin
							raise = 1'b1;
							err   = ERR_TOO_BIG;
						end else begin
							acc_nxt = {acc[VALUE_BITS-5:0], hex_d};
						end
					end else begin
						run_suffix = 1'b1;
					end
				end
				RDX_OCT: begin
					if (is_oct) begin
						if (acc[VALUE_BITS-1 -: 3] != 3'd0) begin
							raise = 1'b1;
							err   = ERR_TOO_BIG;
						end else begin
							acc_nxt = {acc[VALUE_BITS-4:0], dec_d[2:0]};
						end
					end else if (is_oct_bad) begin
						raise = 1'b1;
						err   = ERR_INVALID;
					end else begin
						run_suffix = 1'b1;
					end
				end
				default: begin
					if (is_bin) begin
						acc_nxt             = {acc[VALUE_BITS-2:0], dec_d[0]};
						ctl_nxt.digit_count = dc_inc;
						if (dc_inc > BIN_LIM) begin
							raise = 1'b1;
							err   = ERR_TOO_BIG;
						end
					end else begin
						run_suffix = 1'b1;
					end
				end
			endcase
			if (run_suffix)
				ctl_nxt.phase = PH_SUFFIX;
		end

		// Suffix letters
		if (run_suffix) begin
			if (is_u)
				ctl_nxt.unsigned_seen = 1'b1;
			else if (is_l)
				ctl_nxt.long_seen = 1'b1;
			else begin
				raise = 1'b1;
				err   = ERR_INVALID;
			end
		end

		// Keep only the first error, then drain
		if (raise) begin
			if (ctl.first_error == ERR_NONE)
				ctl_nxt.first_error = err;
			ctl_nxt.phase = PH_DRAIN;
		end
	end

endmodule

[hdl/ilp_emit.sv]
// Result formatting on the terminating zero byte.
// Sign-extends the value and derives type class, signedness and error.
// Depends on ilp_pkg.
module ilp_emit #(
	parameter int VALUE_BITS = 64
) (
	input  logic [VALUE_BITS-1:0] acc,
	input  ilp_pkg::ctl_t         ctl,
	output logic [63:0]           value,
	output logic [1:0]            type_class,
	output logic                  signed_flag,
	output logic [1:0]            error
);
	import ilp_pkg::*;

	localparam logic [VALUE_BITS-1:0] INT_LIM   = VALUE_BITS'(2147483647);
	localparam logic [VALUE_BITS-1:0] SHORT_LIM = VALUE_BITS'(32767);

	assign value = 64'(signed'(acc));

	// Class by signed compare; l suffix lifts int to long
	always_comb begin
		priority if ($signed(acc) > $signed(INT_LIM))
			type_class = CLS_WIDE;
		else if ($signed(acc) > $signed(SHORT_LIM))
			type_class = CLS_LONG;
		else if (ctl.long_seen)
			type_class = CLS_LONG;
		else
			type_class = CLS_INT;
	end

	assign signed_flag = ~ctl.unsigned_seen;
	assign error       = ctl.first_error;

endmodule
